FILE: src/pcm_voice_mixer_with_stealing_defines.svh
// Assertion macros used by the voice mixer datapath.
`ifndef PCM_VOICE_MIXER_WITH_STEALING_DEFINES_SVH
`define PCM_VOICE_MIXER_WITH_STEALING_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PVM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the clock cycle after the antecedent.
`define PVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pvm_pkg.sv
// Types and constants shared by the voice mixer modules.
package pvm_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_PLAY  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [6:0]  PERCENT_FULL  = 7'd100;
  localparam logic [8:0]  KILL_SPAN     = 9'd256;
  localparam logic [16:0] FADE_IN_SPAN  = 17'd128;
  localparam logic [16:0] FADE_OUT_SPAN = 17'd96;
  localparam logic [9:0]  RECIP_THREE   = 10'd683;
  localparam int          SAT_LIMIT     = 32760;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_RED_STEP,
    OP_MEM_WR,
    OP_SEL_SCAN,
    OP_MARK,
    OP_PLAY_WR,
    OP_V_LOAD,
    OP_V_SKIP,
    OP_V_F1,
    OP_V_F2,
    OP_V_F3,
    OP_V_F4,
    OP_V_F5,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } pvm_op_t;

  typedef struct packed {
    pvm_op_t op;
  } pvm_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       red_done;
    logic       master_zero;
    logic       vlast;
    logic       play_ok;
    logic       voice_run;
    logic       grain_zero;
    logic       div_last;
    logic       out_free;
  } pvm_stat_t;

endpackage

FILE: src/pvm_in_if.sv
// Request channel interface.
interface pvm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [15:0]        mem_addr;
  logic signed [15:0] sample_data;
  logic [15:0]        play_start;
  logic [16:0]        play_length;
  logic [8:0]         play_volume;

  modport source (output valid, req_type, mem_addr, sample_data, play_start, play_length,
                  play_volume, input ready);
  modport sink (input valid, req_type, mem_addr, sample_data, play_start, play_length,
                play_volume, output ready);
endinterface

FILE: src/pvm_out_if.sv
// Mixed sample channel interface.
interface pvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink (input valid, mixed_sample, output ready);
endinterface

FILE: src/pvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: src/pvm_ctrl.sv
// Sequencing state machine of the voice mixer.
module pvm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pvm_pkg::pvm_stat_t  stat,
  output pvm_pkg::pvm_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RED, S_WR, S_SCAN, S_CHK, S_MARK, S_PWR,
    S_VLOAD, S_F1, S_F2, S_F3, S_F4, S_F5, S_END, S_DINIT, S_DSTEP, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = pvm_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = pvm_pkg::OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.req_type)
          pvm_pkg::REQ_WRITE: state_nxt = S_RED;
          pvm_pkg::REQ_PLAY:  state_nxt = stat.master_zero ? S_IDLE : S_RED;
          pvm_pkg::REQ_TICK:  state_nxt = S_VLOAD;
          default:            state_nxt = S_IDLE;
        endcase
      end
      S_RED: begin
        cmd.op = pvm_pkg::OP_RED_STEP;
        if (stat.red_done) begin
          state_nxt = (stat.req_type == pvm_pkg::REQ_WRITE) ? S_WR : S_SCAN;
        end
      end
      S_WR: begin
        cmd.op    = pvm_pkg::OP_MEM_WR;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.op = pvm_pkg::OP_SEL_SCAN;
        if (stat.vlast) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = stat.play_ok ? S_MARK : S_IDLE;
      end
      S_MARK: begin
        cmd.op = pvm_pkg::OP_MARK;
        if (stat.vlast) begin
          state_nxt = S_PWR;
        end
      end
      S_PWR: begin
        cmd.op    = pvm_pkg::OP_PLAY_WR;
        state_nxt = S_IDLE;
      end
      S_VLOAD: begin
        if (stat.voice_run) begin
          cmd.op    = pvm_pkg::OP_V_LOAD;
          state_nxt = S_F1;
        end else begin
          cmd.op = pvm_pkg::OP_V_SKIP;
          if (stat.vlast) begin
            state_nxt = S_END;
          end
        end
      end
      S_F1: begin
        cmd.op    = pvm_pkg::OP_V_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.op    = pvm_pkg::OP_V_F2;
        state_nxt = S_F3;
      end
      S_F3: begin
        cmd.op    = pvm_pkg::OP_V_F3;
        state_nxt = S_F4;
      end
      S_F4: begin
        cmd.op    = pvm_pkg::OP_V_F4;
        state_nxt = S_F5;
      end
      S_F5: begin
        cmd.op    = pvm_pkg::OP_V_F5;
        state_nxt = stat.vlast ? S_END : S_VLOAD;
      end
      S_END: begin
        state_nxt = stat.grain_zero ? S_DINIT : S_OUT;
      end
      S_DINIT: begin
        cmd.op    = pvm_pkg::OP_DIV_INIT;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = pvm_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = pvm_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/pvm_datapath.sv
// Voice state, sample memory, mixing arithmetic and output register.
`include "pcm_voice_mixer_with_stealing_defines.svh"

module pvm_datapath #(
  parameter int VOICE_COUNT         = 32,
  parameter int GRAIN_LENGTH        = 1024,
  parameter int SAMPLE_MEMORY_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pvm_pkg::pvm_cmd_t  cmd,
  output pvm_pkg::pvm_stat_t stat,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_mem_addr,
  input  logic signed [15:0] in_sample_data,
  input  logic [15:0]        in_play_start,
  input  logic [16:0]        in_play_length,
  input  logic [8:0]         in_play_volume,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mixed_sample,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  output logic [6:0]         master_volume
);

  localparam int VIW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNTW = $clog2(VOICE_COUNT + 1);
  localparam int AW   = $clog2(SAMPLE_MEMORY_WORDS);
  localparam int GW   = (GRAIN_LENGTH > 1) ? $clog2(GRAIN_LENGTH) : 1;
  localparam int ACCW = 18 + VIW;
  localparam int FW   = ACCW + 10;
  localparam logic [VIW-1:0] LAST_VOICE = VIW'(VOICE_COUNT - 1);
  localparam logic [GW-1:0]  LAST_GRAIN = GW'(GRAIN_LENGTH - 1);
  localparam logic [AW-1:0]  LAST_WORD  = AW'(SAMPLE_MEMORY_WORDS - 1);
  localparam logic [20:0]    WORDS      = 21'(SAMPLE_MEMORY_WORDS);
  localparam logic signed [FW-1:0] SAT_HI = FW'(pvm_pkg::SAT_LIMIT);
  localparam logic signed [FW-1:0] SAT_LO = -SAT_HI;

  logic [15:0]     vstart_r [VOICE_COUNT];
  logic [16:0]     vlen_r   [VOICE_COUNT];
  logic [16:0]     vpos_r   [VOICE_COUNT];
  logic [8:0]      vgain_r  [VOICE_COUNT];
  logic            vact_r   [VOICE_COUNT];
  logic [8:0]      vkill_r  [VOICE_COUNT];
  logic [AW-1:0]   vaddr_r  [VOICE_COUNT];

  logic [VIW-1:0]  vidx_r;
  logic [1:0]      req_type_r;
  logic [15:0]     red_r;
  logic [15:0]     wdata_r;
  logic [15:0]     pstart_r;
  logic [16:0]     plen_r;
  logic [8:0]      pvol_r;
  logic [VIW-1:0]  s1_r, s2_r, s3_r;
  logic            s1v_r, s2v_r;
  logic [16:0]     best_r;
  logic signed [ACCW-1:0] acc_r;
  logic [CNTW-1:0] cnt_r;
  logic [8:0]      g_r;
  logic [10:0]     t_r;
  logic [8:0]      scale_r;
  logic [GW-1:0]   grain_r;
  logic [14:0]     drem_r;
  logic [20:0]     dsh_r;
  logic [3:0]      dcnt_r;
  logic            out_vld_r;
  logic signed [15:0] out_r;
  logic [6:0]      master_r;

  logic [15:0]     cur_start;
  logic [16:0]     cur_len, cur_pos, cur_rem;
  logic [8:0]      cur_gain, cur_kill;
  logic            cur_act;
  logic [VIW-1:0]  slot;
  logic            red_done;
  logic [15:0]     rd;
  logic [15:0]     fin_prod, fout_prod;
  logic [20:0]     r3_prod;
  logic [17:0]     kill_prod;
  logic signed [25:0] sx, gx, samp_prod;
  logic signed [17:0] contrib;
  logic signed [FW-1:0] fprod, fsh;
  logic [CNTW-1:0] cnt1;
  logic [12:0]     dv;
  logic            dbit;

  assign cur_start = vstart_r[vidx_r];
  assign cur_len   = vlen_r[vidx_r];
  assign cur_pos   = vpos_r[vidx_r];
  assign cur_gain  = vgain_r[vidx_r];
  assign cur_kill  = vkill_r[vidx_r];
  assign cur_act   = vact_r[vidx_r];
  assign cur_rem   = cur_len - cur_pos;

  assign slot     = s1v_r ? s1_r : (s2v_r ? s2_r : s3_r);
  assign red_done = {5'b0, red_r} < WORDS;

  assign fin_prod  = 16'(cur_gain) * 16'(cur_pos[6:0]);
  assign fout_prod = 16'(g_r) * 16'(cur_rem[6:0]);
  assign r3_prod   = 21'(t_r) * 21'(pvm_pkg::RECIP_THREE);
  assign kill_prod = 18'(g_r) * 18'(cur_kill);
  assign sx        = 26'($signed(rd));
  assign gx        = $signed({17'b0, g_r});
  assign samp_prod = sx * gx;
  assign contrib   = samp_prod[25] ? 18'((samp_prod + 26'sd255) >>> 8) : 18'(samp_prod >>> 8);
  assign fprod     = FW'(acc_r) * $signed({{(FW - 9){1'b0}}, scale_r});
  assign fsh       = fprod >>> 8;
  assign cnt1      = (cnt_r == '0) ? CNTW'(1) : cnt_r;
  assign dv        = 13'(pvm_pkg::PERCENT_FULL) * 13'(cnt1);
  assign dbit      = (21'(drem_r) >= dsh_r);

  assign stat.req_type    = req_type_r;
  assign stat.red_done    = red_done;
  assign stat.master_zero = (master_r == '0);
  assign stat.vlast       = (vidx_r == LAST_VOICE);
  assign stat.play_ok     = s1v_r || s2v_r || (best_r != '0);
  assign stat.voice_run   = cur_act && (cur_pos < cur_len);
  assign stat.grain_zero  = (grain_r == '0);
  assign stat.div_last    = (dcnt_r == 4'd8);
  assign stat.out_free    = !out_vld_r || out_ready;

  assign out_valid        = out_vld_r;
  assign out_mixed_sample = out_r;
  assign master_volume    = master_r;

  pvm_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_MEMORY_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.op == pvm_pkg::OP_MEM_WR),
    .waddr (AW'(red_r)),
    .wdata (wdata_r),
    .re    (cmd.op == pvm_pkg::OP_V_LOAD),
    .raddr (vaddr_r[vidx_r]),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        vstart_r[i] <= '0;
        vlen_r[i]   <= '0;
        vpos_r[i]   <= '0;
        vgain_r[i]  <= '0;
        vact_r[i]   <= 1'b0;
        vkill_r[i]  <= '0;
        vaddr_r[i]  <= '0;
      end
      vidx_r    <= '0;
      req_type_r <= pvm_pkg::REQ_WRITE;
      s1v_r     <= 1'b0;
      s2v_r     <= 1'b0;
      best_r    <= '0;
      cnt_r     <= '0;
      scale_r   <= '0;
      grain_r   <= '0;
      dcnt_r    <= '0;
      out_vld_r <= 1'b0;
      master_r  <= pvm_pkg::PERCENT_FULL;
    end else begin
      if (cfg_we) begin
        master_r <= (cfg_wdata > pvm_pkg::PERCENT_FULL) ? pvm_pkg::PERCENT_FULL : cfg_wdata;
      end
      if (out_vld_r && out_ready && cmd.op != pvm_pkg::OP_OUT) begin
        out_vld_r <= 1'b0;
      end
      case (cmd.op)
        pvm_pkg::OP_LATCH: begin
          req_type_r <= in_req_type;
          red_r      <= (in_req_type == pvm_pkg::REQ_WRITE) ? in_mem_addr : in_play_start;
          wdata_r    <= in_sample_data;
          pstart_r   <= in_play_start;
          plen_r     <= in_play_length;
          pvol_r     <= in_play_volume;
          vidx_r     <= '0;
          s1v_r      <= 1'b0;
          s2v_r      <= 1'b0;
          best_r     <= '0;
          s3_r       <= '0;
          cnt_r      <= '0;
          acc_r      <= '0;
        end
        pvm_pkg::OP_RED_STEP: begin
          if (!red_done) begin
            red_r <= red_r - WORDS[15:0];
          end
        end
        pvm_pkg::OP_SEL_SCAN: begin
          if (!s1v_r && !cur_act) begin
            s1v_r <= 1'b1;
            s1_r  <= vidx_r;
          end
          if (!s2v_r && cur_kill != '0) begin
            s2v_r <= 1'b1;
            s2_r  <= vidx_r;
          end
          if (cur_pos > best_r) begin
            best_r <= cur_pos;
            s3_r   <= vidx_r;
          end
          vidx_r <= (vidx_r == LAST_VOICE) ? '0 : vidx_r + 1'b1;
        end
        pvm_pkg::OP_MARK: begin
          if (vidx_r != slot && cur_act && cur_start == pstart_r && cur_kill == '0) begin
            vkill_r[vidx_r] <= pvm_pkg::KILL_SPAN;
          end
          vidx_r <= (vidx_r == LAST_VOICE) ? '0 : vidx_r + 1'b1;
        end
        pvm_pkg::OP_PLAY_WR: begin
          vstart_r[slot] <= pstart_r;
          vlen_r[slot]   <= plen_r;
          vpos_r[slot]   <= '0;
          vgain_r[slot]  <= pvol_r;
          vact_r[slot]   <= 1'b1;
          vkill_r[slot]  <= '0;
          vaddr_r[slot]  <= AW'(red_r);
        end
        pvm_pkg::OP_V_LOAD: begin
          cnt_r <= cnt_r + 1'b1;
        end
        pvm_pkg::OP_V_SKIP: begin
          if (cur_act) begin
            cnt_r           <= cnt_r + 1'b1;
            vact_r[vidx_r]  <= 1'b0;
            vkill_r[vidx_r] <= '0;
          end
          vidx_r <= (vidx_r == LAST_VOICE) ? '0 : vidx_r + 1'b1;
        end
        pvm_pkg::OP_V_F1: begin
          g_r <= (cur_pos < pvm_pkg::FADE_IN_SPAN) ? fin_prod[15:7] : cur_gain;
        end
        pvm_pkg::OP_V_F2: begin
          t_r <= fout_prod[15:5];
        end
        pvm_pkg::OP_V_F3: begin
          if (cur_rem < pvm_pkg::FADE_OUT_SPAN) begin
            g_r <= r3_prod[19:11];
          end
        end
        pvm_pkg::OP_V_F4: begin
          if (cur_kill != '0) begin
            g_r <= kill_prod[16:8];
          end
        end
        pvm_pkg::OP_V_F5: begin
          acc_r          <= acc_r + ACCW'(contrib);
          vpos_r[vidx_r] <= cur_pos + 1'b1;
          vaddr_r[vidx_r] <= (vaddr_r[vidx_r] == LAST_WORD) ? '0 : vaddr_r[vidx_r] + 1'b1;
          if (cur_kill != '0) begin
            vkill_r[vidx_r] <= cur_kill - 1'b1;
            if (cur_kill == 9'd1) begin
              vact_r[vidx_r] <= 1'b0;
            end
          end
          vidx_r <= (vidx_r == LAST_VOICE) ? '0 : vidx_r + 1'b1;
        end
        pvm_pkg::OP_DIV_INIT: begin
          drem_r  <= {master_r, 8'b0};
          dsh_r   <= {dv, 8'b0};
          scale_r <= '0;
          dcnt_r  <= '0;
        end
        pvm_pkg::OP_DIV_STEP: begin
          if (dbit) begin
            drem_r <= drem_r - 15'(dsh_r);
          end
          scale_r <= {scale_r[7:0], dbit};
          dsh_r   <= dsh_r >> 1;
          dcnt_r  <= dcnt_r + 1'b1;
        end
        pvm_pkg::OP_OUT: begin
          out_vld_r <= 1'b1;
          if (fsh > SAT_HI) begin
            out_r <= 16'(SAT_HI);
          end else if (fsh < SAT_LO) begin
            out_r <= 16'(SAT_LO);
          end else begin
            out_r <= 16'(fsh);
          end
          grain_r <= (grain_r == LAST_GRAIN) ? '0 : grain_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  `PVM_ASSERT_ALWAYS(a_scale_range, scale_r <= 9'd256, "mix scale above unity")
  `PVM_ASSERT_ALWAYS(a_out_sat, !out_vld_r || (out_r <= 16'sd32760 && out_r >= -16'sd32760), "output sample outside saturation range")
  `PVM_ASSERT_NEXT(a_out_load, cmd.op == pvm_pkg::OP_OUT, out_vld_r, "mixed sample not presented after tick")
  `PVM_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CNTW'(VOICE_COUNT), "active voice count above voice count")

endmodule

FILE: src/pcm_voice_mixer_with_stealing.sv
// Top level of the multi-voice PCM mixer with voice stealing.
// Requests are processed one at a time. A memory write latches the request, reduces
// the address by each whole multiple of the memory depth (none at the default depth)
// and writes the word. A play makes one scan of the voice table to choose a voice
// and one to start kill fades. A tick runs the six-step per-voice multiply chain for
// each sounding voice and a single skip step for each other voice, and at the start
// of a grain it also runs the bit-serial scale divider.
// The mixed sample sits in an output register, so the next request may start while
// it waits to be taken.
module pcm_voice_mixer_with_stealing #(
  parameter int VOICE_COUNT         = 32,
  parameter int GRAIN_LENGTH        = 1024,
  parameter int SAMPLE_MEMORY_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  pvm_in_if.sink      in_ch,
  pvm_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pvm_pkg::pvm_cmd_t  cmd;
  pvm_pkg::pvm_stat_t stat;
  logic [6:0]         master;
  logic               cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(master);

  pvm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pvm_datapath #(
    .VOICE_COUNT         (VOICE_COUNT),
    .GRAIN_LENGTH        (GRAIN_LENGTH),
    .SAMPLE_MEMORY_WORDS (SAMPLE_MEMORY_WORDS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_ch.req_type),
    .in_mem_addr      (in_ch.mem_addr),
    .in_sample_data   (in_ch.sample_data),
    .in_play_start    (in_ch.play_start),
    .in_play_length   (in_ch.play_length),
    .in_play_volume   (in_ch.play_volume),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_mixed_sample (out_ch.mixed_sample),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_pwdata[6:0]),
    .master_volume    (master)
  );

endmodule
